>>> hw/rtl/vasc_pkg.sv
// Package for the vehicle axle speed classifier.
// Holds widths, reset values and the packed layout of the output transfer.
// No dependencies.
`default_nettype none

package vasc_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int LOG_DEPTH        = 256;

    localparam int MS_W    = $clog2(TICKS_PER_SECOND);
    localparam int SLOT_W  = $clog2(LOG_DEPTH);
    localparam int LIMIT_W = 11;
    localparam int DIST_W  = 16;
    localparam int TIME_W  = 16;
    localparam int TOT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 112;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_FACTOR = 2'd1;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST     = 11'd60;
    localparam logic [DIST_W-1:0]  DISTANCE_FACTOR_RST = 16'd1440;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    typedef struct packed {
        logic [5:0]       pad;
        logic [TOT_W-1:0] speeding_total;
        logic [TOT_W-1:0] heavy_total;
        logic [TOT_W-1:0] two_axle_total;
        logic [TOT_W-1:0] vehicles_total;
        logic [7:0]       record_slot;
        logic [5:0]       record_second;
        logic [5:0]       record_minute;
        logic [4:0]       record_hour;
        logic [7:0]       record_speed;
        logic [7:0]       record_axles;
        logic             camera_out;
    } t_out_data;

endpackage

`default_nettype wire

>>> hw/rtl/vehicle_axle_speed_classifier.sv
// Vehicle axle speed classifier: time-of-day clock, axle counting, speed by a
// bit-serial restoring divider and vehicle records. Depends on vasc_pkg.
// A tick gives no output. An event passes through ST_OUT and offers its output once the output
// register is free; a speed measurement first runs 16 divider steps and a compare step before
// the output load. A full output register holds the event.
// Synchronous active-low reset clears the state, time, run and total registers and loads the register defaults.
`default_nettype none

module vehicle_axle_speed_classifier (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [vasc_pkg::IN_W-1:0]            s_axis_tdata,  // loop_active, cable_one, cable_two
    input  wire                                  s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [vasc_pkg::OUT_W-1:0]           m_axis_tdata,  // camera_out, record_axles,
                                                                // record_speed, record_hour,
                                                                // record_minute, record_second,
                                                                // record_slot, vehicles_total,
                                                                // two_axle_total, heavy_total,
                                                                // speeding_total
    output logic                                 m_axis_tuser,  // record_valid
    input  wire                                  i_cfg_we,
    input  wire  [vasc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [vasc_pkg::CFG_W-1:0]           i_cfg_data
);
    import vasc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         r_state;
    logic [LIMIT_W-1:0] r_speed_limit;
    logic [DIST_W-1:0]  r_distance_factor;

    logic [TIME_W-1:0]  r_ms_count;
    logic [MS_W-1:0]    r_ms_in_sec;
    logic [5:0]         r_seconds;
    logic [5:0]         r_minutes;
    logic [4:0]         r_hours;
    logic [7:0]         r_axles;
    logic [TIME_W-1:0]  r_start;
    logic [15:0]        r_speed;
    logic               r_camera;
    logic [SLOT_W-1:0]  r_slot;
    logic [TOT_W-1:0]   r_vehicles;
    logic [TOT_W-1:0]   r_two_axle;
    logic [TOT_W-1:0]   r_heavy;
    logic [TOT_W-1:0]   r_speeding;

    logic               r_rec_valid;
    logic [7:0]         r_rec_axles;
    logic [7:0]         r_rec_speed;
    logic [4:0]         r_rec_hour;
    logic [5:0]         r_rec_minute;
    logic [5:0]         r_rec_second;
    logic [7:0]         r_rec_slot;

    logic [15:0]        r_quot;
    logic [15:0]        r_rem;
    logic [15:0]        r_divisor;
    logic [3:0]         r_cnt;

    logic               r_m_valid;
    logic               r_m_user;
    t_out_data          r_m_data;

    logic               w_in_fire;
    logic               w_loop;
    logic               w_c1;
    logic               w_c2;
    logic [7:0]         n_axles;
    logic [TIME_W-1:0]  n_start;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_need_div;
    logic [16:0]        w_rem_sh;
    logic [16:0]        w_rem_diff;
    logic               w_rem_ge;
    logic               w_out_free;
    t_out_data          n_m_data;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_loop     = s_axis_tdata[0];
    assign w_c1       = s_axis_tdata[1];
    assign w_c2       = s_axis_tdata[2];
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_axles    = w_c1 ? r_axles + 8'd1 : r_axles;
        n_start    = (w_c1 && n_axles == 8'd1) ? r_ms_count : r_start;
        w_elapsed  = r_ms_count - n_start;
        w_need_div = w_c2 && (n_axles == 8'd1) && (w_elapsed != '0);
    end

    always_comb begin
        w_rem_sh   = {r_rem, r_quot[15]};
        w_rem_diff = w_rem_sh - {1'b0, r_divisor};
        w_rem_ge   = !w_rem_diff[16];
    end

    always_comb begin
        n_m_data                = '0;
        n_m_data.camera_out     = r_camera;
        n_m_data.vehicles_total = r_vehicles;
        n_m_data.two_axle_total = r_two_axle;
        n_m_data.heavy_total    = r_heavy;
        n_m_data.speeding_total = r_speeding;
        if (r_rec_valid) begin
            n_m_data.record_axles  = r_rec_axles;
            n_m_data.record_speed  = r_rec_speed;
            n_m_data.record_hour   = r_rec_hour;
            n_m_data.record_minute = r_rec_minute;
            n_m_data.record_second = r_rec_second;
            n_m_data.record_slot   = r_rec_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit     <= SPEED_LIMIT_RST;
            r_distance_factor <= DISTANCE_FACTOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPEED_LIMIT:     r_speed_limit     <= i_cfg_data[LIMIT_W-1:0];
                REG_DISTANCE_FACTOR: r_distance_factor <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ms_count  <= '0;
            r_ms_in_sec <= '0;
            r_seconds   <= '0;
            r_minutes   <= '0;
            r_hours     <= '0;
            r_axles     <= '0;
            r_start     <= '0;
            r_speed     <= '0;
            r_camera    <= 1'b0;
            r_slot      <= '0;
            r_vehicles  <= '0;
            r_two_axle  <= '0;
            r_heavy     <= '0;
            r_speeding  <= '0;
            r_rec_valid <= 1'b0;
            r_cnt       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (r_state == ST_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire && !s_axis_tuser) begin
                        r_ms_count <= r_ms_count + 16'd1;
                        if (r_ms_in_sec == MS_W'(TICKS_PER_SECOND - 1)) begin
                            r_ms_in_sec <= '0;
                            if (r_seconds == SEC_LAST) begin
                                r_seconds <= '0;
                                if (r_minutes == MIN_LAST) begin
                                    r_minutes <= '0;
                                    r_hours   <= (r_hours == HOUR_LAST) ? 5'd0
                                                                        : r_hours + 5'd1;
                                end else begin
                                    r_minutes <= r_minutes + 6'd1;
                                end
                            end else begin
                                r_seconds <= r_seconds + 6'd1;
                            end
                        end else begin
                            r_ms_in_sec <= r_ms_in_sec + MS_W'(1);
                        end
                    end else if (w_in_fire) begin
                        if (w_loop) begin
                            r_rec_valid <= 1'b0;
                            r_axles     <= n_axles;
                            r_start     <= n_start;
                            if (w_need_div) begin
                                r_divisor <= w_elapsed;
                                r_quot    <= r_distance_factor;
                                r_rem     <= '0;
                                r_cnt     <= '0;
                                r_state   <= ST_DIV;
                            end else begin
                                r_state   <= ST_OUT;
                            end
                        end else if (r_axles != 8'd0) begin
                            r_rec_valid  <= 1'b1;
                            r_state      <= ST_OUT;
                            r_rec_axles  <= r_axles;
                            r_rec_speed  <= r_speed[7:0];
                            r_rec_hour   <= r_hours;
                            r_rec_minute <= r_minutes;
                            r_rec_second <= r_seconds;
                            r_rec_slot   <= 8'(r_slot);
                            r_vehicles   <= r_vehicles + 16'd1;
                            if (r_axles == 8'd2) begin
                                r_two_axle <= r_two_axle + 16'd1;
                            end else if (r_axles > 8'd2) begin
                                r_heavy <= r_heavy + 16'd1;
                            end
                            if (r_speed > {5'd0, r_speed_limit}) begin
                                r_speeding <= r_speeding + 16'd1;
                            end
                            r_slot  <= (r_slot == SLOT_W'(LOG_DEPTH - 1)) ? '0
                                                                         : r_slot + SLOT_W'(1);
                            r_axles <= '0;
                            r_speed <= '0;
                            r_start <= '0;
                        end else begin
                            r_rec_valid <= 1'b0;
                            r_state     <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem  <= w_rem_ge ? w_rem_diff[15:0] : w_rem_sh[15:0];
                    r_quot <= {r_quot[14:0], w_rem_ge};
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_speed <= r_quot;
                    if (r_quot > {5'd0, r_speed_limit}) begin
                        r_camera <= !r_camera;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_m_data <= n_m_data;
            r_m_user <= r_rec_valid;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_record_has_axles : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_m_data.record_axles != 8'd0))
        else $error("record emitted with zero axles");

    a_hour_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hours <= HOUR_LAST)
        else $error("hour counter out of range");

    a_divisor_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_divisor != '0))
        else $error("divider running with zero elapsed time");

    a_tick_keeps_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !s_axis_tuser) |=> ($stable(r_axles) && $stable(r_vehicles)))
        else $error("tick transfer changed vehicle state");

endmodule

`default_nettype wire
